@@ rtl/lhm_pkg.sv @@
// Shared types, widths and constant tables of the latency histogram monitor.
`default_nettype none

package lhm_pkg;

    // Field widths
    localparam int METRIC_W  = 4;   // holds any metric index up to sixteen metrics
    localparam int LAT_W     = 32;
    localparam int BUCKET_W  = 4;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 64;
    localparam int CENTER_W  = 23;

    // Running total of up to ten 32-bit bucket counts, plus one
    localparam int CUM_W     = 36;
    // Scaled compare width: running total times one hundred
    localparam int PROD_W    = 43;

    // Percentile scale factors
    localparam int PCT_SCALE = 100;
    localparam int PCT_P95   = 95;
    localparam int PCT_P99   = 99;

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [LAT_W-1:0] MIN_RESET_US = 32'd999999000;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 1'b0;

    // Bucket upper bounds in us; the last bucket is open ended
    localparam logic [LAT_W-1:0] BOUND_US [0:8] = '{
        32'd10000,  32'd25000,  32'd50000,   32'd100000, 32'd250000,
        32'd500000, 32'd1000000, 32'd2500000, 32'd5000000
    };

    // Bucket centers in us
    localparam logic [CENTER_W-1:0] CENTER_US [0:9] = '{
        23'd5000,   23'd17500,  23'd37500,   23'd75000,   23'd175000,
        23'd375000, 23'd750000, 23'd1750000, 23'd3750000, 23'd7500000
    };

    // One classified sample travelling from front to back
    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [LAT_W-1:0]    latency;
        logic [BUCKET_W-1:0] bucket;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STAT,
        ST_WALK,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/lhm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lhm_front.sv @@
// Front end: takes samples, drops disabled or out-of-range ones, picks the bucket, queues.
`default_nettype none

module lhm_front #(
    parameter int NUM_METRICS = 3,
    parameter int NUM_BUCKETS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          enable,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_metric,
    input  wire logic [lhm_pkg::LAT_W-1:0]     s_latency_us,
    output logic                               q_valid,
    output lhm_pkg::item_t                     q_item,
    input  wire logic                          q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    lhm_pkg::item_t           slot_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]        wr_ptr_reg;
    logic [QPTR_W-1:0]        rd_ptr_reg;
    logic [QCNT_W-1:0]        count_reg;
    logic [QCNT_W-1:0]        count_next;
    logic                     accept;
    logic                     in_range;
    logic                     push;
    logic [lhm_pkg::BUCKET_W-1:0] bucket;
    lhm_pkg::item_t           item;

    // Bucket pick: first bound the latency lies below, else the last bucket
    always_comb begin
        bucket = lhm_pkg::BUCKET_W'(NUM_BUCKETS - 1);
        for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
            if (s_latency_us < lhm_pkg::BOUND_US[i]) begin
                bucket = lhm_pkg::BUCKET_W'(i);
            end
        end
    end

    // Acceptance and filtering
    assign s_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_metric) < NUM_METRICS);
    assign push     = accept && enable && in_range;

    always_comb begin
        item.metric  = lhm_pkg::METRIC_W'(s_metric);
        item.latency = s_latency_us;
        item.bucket  = bucket;
    end

    // Queue toward the back end
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill exceeds its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/lhm_back.sv @@
// Back end: per-metric statistics update, bucket count update and percentile walk.
`default_nettype none

module lhm_back #(
    parameter int NUM_METRICS = 3,
    parameter int NUM_BUCKETS = 10
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire lhm_pkg::item_t                   q_item,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lhm_pkg::BUCKET_W-1:0]          m_bucket,
    output logic [lhm_pkg::CNT_W-1:0]             m_sample_count,
    output logic [lhm_pkg::LAT_W-1:0]             m_min_us,
    output logic [lhm_pkg::LAT_W-1:0]             m_max_us,
    output logic [lhm_pkg::SUM_W-1:0]             m_sum_us,
    output logic [lhm_pkg::CENTER_W-1:0]          m_p50_us,
    output logic [lhm_pkg::CENTER_W-1:0]          m_p95_us,
    output logic [lhm_pkg::CENTER_W-1:0]          m_p99_us
);

    localparam int MIDX_W = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int DEPTH  = NUM_METRICS * NUM_BUCKETS;
    localparam int AW     = $clog2(DEPTH);
    localparam logic [lhm_pkg::BUCKET_W-1:0] LAST_IDX = lhm_pkg::BUCKET_W'(NUM_BUCKETS - 1);
    localparam logic [lhm_pkg::CENTER_W-1:0] TOP_CENTER = lhm_pkg::CENTER_US[NUM_BUCKETS - 1];

    function automatic logic [lhm_pkg::CNT_W-1:0] sat_inc(input logic [lhm_pkg::CNT_W-1:0] v);
        return (v == lhm_pkg::CNT_MAX) ? v : v + lhm_pkg::CNT_W'(1);
    endfunction

    // Sequencer
    lhm_pkg::back_state_t state_reg;
    lhm_pkg::back_state_t state_next;
    logic stat_load;
    logic walk_en;
    logic emit_load;
    logic walk_done;
    logic out_free;

    // Current item
    logic [MIDX_W-1:0]               metric_reg;
    logic [lhm_pkg::LAT_W-1:0]       lat_reg;
    logic [lhm_pkg::BUCKET_W-1:0]    bucket_reg;
    logic [AW-1:0]                   base_reg;

    // Per-metric statistics
    logic [lhm_pkg::CNT_W-1:0] cnt_arr_reg [0:NUM_METRICS-1];
    logic [lhm_pkg::LAT_W-1:0] min_arr_reg [0:NUM_METRICS-1];
    logic [lhm_pkg::LAT_W-1:0] max_arr_reg [0:NUM_METRICS-1];
    logic [lhm_pkg::SUM_W-1:0] sum_arr_reg [0:NUM_METRICS-1];

    logic [lhm_pkg::CNT_W-1:0] cnt_next;
    logic [lhm_pkg::LAT_W-1:0] min_next;
    logic [lhm_pkg::LAT_W-1:0] max_next;
    logic [lhm_pkg::SUM_W-1:0] sum_next;
    logic [lhm_pkg::SUM_W:0]   sum_wide;

    logic [lhm_pkg::CNT_W-1:0] res_cnt_reg;
    logic [lhm_pkg::LAT_W-1:0] res_min_reg;
    logic [lhm_pkg::LAT_W-1:0] res_max_reg;
    logic [lhm_pkg::SUM_W-1:0] res_sum_reg;

    // Walk pipeline: issue read, accumulate, compare
    logic                          issue_vld_reg;
    logic [lhm_pkg::BUCKET_W-1:0]  rd_idx_reg;
    logic                          b_vld_reg;
    logic [lhm_pkg::BUCKET_W-1:0]  b_idx_reg;
    logic                          c_vld_reg;
    logic [lhm_pkg::BUCKET_W-1:0]  c_idx_reg;
    logic                          vbit_reg;
    logic [DEPTH-1:0]              valid_reg;
    logic [lhm_pkg::CUM_W-1:0]     cum_reg;    // running total plus one
    logic [lhm_pkg::PROD_W-1:0]    k95_reg;
    logic [lhm_pkg::PROD_W-1:0]    k99_reg;
    logic                          f50_reg;
    logic                          f95_reg;
    logic                          f99_reg;
    logic [lhm_pkg::CENTER_W-1:0]  p50_reg;
    logic [lhm_pkg::CENTER_W-1:0]  p95_reg;
    logic [lhm_pkg::CENTER_W-1:0]  p99_reg;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [lhm_pkg::CNT_W-1:0]     ram_rdata;
    logic [lhm_pkg::CNT_W-1:0]     b_data;
    logic [lhm_pkg::CNT_W-1:0]     b_val;
    logic [lhm_pkg::CUM_W:0]       cum_x2;
    logic [lhm_pkg::PROD_W-1:0]    cum_x100;
    logic                          hit50;
    logic                          hit95;
    logic                          hit99;

    // Output register
    logic                            m_valid_reg;
    logic [lhm_pkg::BUCKET_W-1:0]    m_bucket_reg;
    logic [lhm_pkg::CNT_W-1:0]       m_cnt_reg;
    logic [lhm_pkg::LAT_W-1:0]       m_min_reg;
    logic [lhm_pkg::LAT_W-1:0]       m_max_reg;
    logic [lhm_pkg::SUM_W-1:0]       m_sum_reg;
    logic [lhm_pkg::CENTER_W-1:0]    m_p50_reg;
    logic [lhm_pkg::CENTER_W-1:0]    m_p95_reg;
    logic [lhm_pkg::CENTER_W-1:0]    m_p99_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign walk_done = c_vld_reg && (c_idx_reg == LAST_IDX);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lhm_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = lhm_pkg::ST_STAT;
                end
            end
            lhm_pkg::ST_STAT: begin
                state_next = lhm_pkg::ST_WALK;
            end
            lhm_pkg::ST_WALK: begin
                if (walk_done) begin
                    state_next = lhm_pkg::ST_EMIT;
                end
            end
            lhm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = lhm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lhm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        q_pop     = 1'b0;
        stat_load = 1'b0;
        walk_en   = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            lhm_pkg::ST_IDLE: q_pop     = q_valid;
            lhm_pkg::ST_STAT: stat_load = 1'b1;
            lhm_pkg::ST_WALK: walk_en   = 1'b1;
            lhm_pkg::ST_EMIT: emit_load = out_free;
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Saturating statistics update for the current metric
    always_comb begin
        cnt_next = sat_inc(cnt_arr_reg[metric_reg]);
        min_next = (lat_reg < min_arr_reg[metric_reg]) ? lat_reg : min_arr_reg[metric_reg];
        max_next = (lat_reg > max_arr_reg[metric_reg]) ? lat_reg : max_arr_reg[metric_reg];
        sum_wide = {1'b0, sum_arr_reg[metric_reg]} + (lhm_pkg::SUM_W + 1)'(lat_reg);
        sum_next = sum_wide[lhm_pkg::SUM_W] ? '1 : sum_wide[lhm_pkg::SUM_W-1:0];
    end

    // Bucket count memory access
    assign rd_en   = walk_en && issue_vld_reg;
    assign rd_addr = base_reg + AW'(rd_idx_reg);
    assign b_data  = vbit_reg ? ram_rdata : '0;
    assign b_val   = (b_idx_reg == bucket_reg) ? sat_inc(b_data) : b_data;
    assign wr_en   = walk_en && b_vld_reg && (b_idx_reg == bucket_reg);
    assign wr_addr = base_reg + AW'(b_idx_reg);

    lhm_ram #(
        .WIDTH (lhm_pkg::CNT_W),
        .DEPTH (DEPTH)
    ) u_counts (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (b_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // Percentile tests: cum >= floor(cnt*k/100) <=> 100*(cum+1) > cnt*k
    assign cum_x2   = {cum_reg, 1'b0};
    assign cum_x100 = lhm_pkg::PROD_W'(cum_reg) * lhm_pkg::PROD_W'(lhm_pkg::PCT_SCALE);
    assign hit50    = cum_x2 > (lhm_pkg::CUM_W + 1)'(res_cnt_reg);
    assign hit95    = cum_x100 > k95_reg;
    assign hit99    = cum_x100 > k99_reg;

    // Control state and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lhm_pkg::ST_IDLE;
            issue_vld_reg <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            valid_reg     <= '0;
            for (int i = 0; i < NUM_METRICS; i++) begin
                cnt_arr_reg[i] <= '0;
                min_arr_reg[i] <= lhm_pkg::MIN_RESET_US;
                max_arr_reg[i] <= '0;
                sum_arr_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (stat_load) begin
                cnt_arr_reg[metric_reg] <= cnt_next;
                min_arr_reg[metric_reg] <= min_next;
                max_arr_reg[metric_reg] <= max_next;
                sum_arr_reg[metric_reg] <= sum_next;
            end
            // read issue
            if (stat_load) begin
                issue_vld_reg <= 1'b1;
            end else if (rd_en && (rd_idx_reg == LAST_IDX)) begin
                issue_vld_reg <= 1'b0;
            end
            b_vld_reg <= rd_en;
            c_vld_reg <= walk_en && b_vld_reg;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            // result register
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            metric_reg <= MIDX_W'(q_item.metric);
            lat_reg    <= q_item.latency;
            bucket_reg <= q_item.bucket;
        end
        if (stat_load) begin
            base_reg    <= AW'(32'(metric_reg) * NUM_BUCKETS);
            res_cnt_reg <= cnt_next;
            res_min_reg <= min_next;
            res_max_reg <= max_next;
            res_sum_reg <= sum_next;
            rd_idx_reg  <= '0;
            cum_reg     <= lhm_pkg::CUM_W'(1);
            f50_reg     <= 1'b0;
            f95_reg     <= 1'b0;
            f99_reg     <= 1'b0;
            p50_reg     <= TOP_CENTER;
            p95_reg     <= TOP_CENTER;
            p99_reg     <= TOP_CENTER;
        end
        if (walk_en) begin
            k95_reg <= lhm_pkg::PROD_W'(res_cnt_reg) * lhm_pkg::PROD_W'(lhm_pkg::PCT_P95);
            k99_reg <= lhm_pkg::PROD_W'(res_cnt_reg) * lhm_pkg::PROD_W'(lhm_pkg::PCT_P99);
        end
        // issue stage
        if (rd_en) begin
            vbit_reg  <= valid_reg[rd_addr];
            b_idx_reg <= rd_idx_reg;
            if (rd_idx_reg != LAST_IDX) begin
                rd_idx_reg <= rd_idx_reg + lhm_pkg::BUCKET_W'(1);
            end
        end
        // accumulate stage
        if (walk_en && b_vld_reg) begin
            cum_reg   <= cum_reg + lhm_pkg::CUM_W'(b_val);
            c_idx_reg <= b_idx_reg;
        end
        // compare stage
        if (walk_en && c_vld_reg) begin
            if (!f50_reg && hit50) begin
                f50_reg <= 1'b1;
                p50_reg <= lhm_pkg::CENTER_US[c_idx_reg];
            end
            if (!f95_reg && hit95) begin
                f95_reg <= 1'b1;
                p95_reg <= lhm_pkg::CENTER_US[c_idx_reg];
            end
            if (!f99_reg && hit99) begin
                f99_reg <= 1'b1;
                p99_reg <= lhm_pkg::CENTER_US[c_idx_reg];
            end
        end
        if (emit_load) begin
            m_bucket_reg <= bucket_reg;
            m_cnt_reg    <= res_cnt_reg;
            m_min_reg    <= res_min_reg;
            m_max_reg    <= res_max_reg;
            m_sum_reg    <= res_sum_reg;
            m_p50_reg    <= p50_reg;
            m_p95_reg    <= p95_reg;
            m_p99_reg    <= p99_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket       = m_bucket_reg;
    assign m_sample_count = m_cnt_reg;
    assign m_min_us       = m_min_reg;
    assign m_max_us       = m_max_reg;
    assign m_sum_us       = m_sum_reg;
    assign m_p50_us       = m_p50_reg;
    assign m_p95_us       = m_p95_reg;
    assign m_p99_us       = m_p99_reg;

    // Checks
    a_emit_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == lhm_pkg::ST_EMIT))
        else $error("result shown without passing through the emit step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == lhm_pkg::ST_WALK) && (b_idx_reg == bucket_reg))
        else $error("count memory written outside the sample's bucket walk");

    a_walk_index: assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg |-> (c_idx_reg <= LAST_IDX))
        else $error("walk index beyond the last bucket");

endmodule

`default_nettype wire

@@ rtl/latency_histogram_monitor.sv @@
// Top level of the latency histogram monitor: config register, front end and back end.
//
// Usage
//   Input channel s_*: one latency sample per transfer (metric index, latency in us).
//   Result channel m_*: one transfer per recorded sample with the bucket hit, the
//   metric's count, min, max, sum and the bucket-center p50/p95/p99 estimates.
//   Samples that arrive while enable is low, or that name a metric past
//   NUM_METRICS-1, are taken and dropped without a result.
//   Config port: APB-style, register enable at byte address 0 (reset 1).
// Sequence
//   A recorded sample passes in the back end through the queue pop, the statistics
//   update, a walk over the metric's bucket counts in the count memory (one read
//   per cycle, then the accumulate and compare stages), and the load of the result
//   register. The back end takes no new sample from the queue until the last one
//   has gone into the result register. Dropped samples are handled in the front
//   end alone and never reach the back end.
// Reset and stall
//   aresetn clears all counts, sums and maxima, sets minima to 999999000 and
//   enables sampling; the block is ready right after reset. A stalled result
//   holds in the output register; the two-entry queue keeps taking samples
//   until it fills, then s_ready drops.
`default_nettype none

module latency_histogram_monitor #(
    parameter int NUM_METRICS = 3,
    parameter int NUM_BUCKETS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lhm_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    // samples
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_metric,
    input  wire logic [lhm_pkg::LAT_W-1:0]           s_latency_us,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lhm_pkg::BUCKET_W-1:0]             m_bucket,
    output logic [lhm_pkg::CNT_W-1:0]                m_sample_count,
    output logic [lhm_pkg::LAT_W-1:0]                m_min_us,
    output logic [lhm_pkg::LAT_W-1:0]                m_max_us,
    output logic [lhm_pkg::SUM_W-1:0]                m_sum_us,
    output logic [lhm_pkg::CENTER_W-1:0]             m_p50_us,
    output logic [lhm_pkg::CENTER_W-1:0]             m_p95_us,
    output logic [lhm_pkg::CENTER_W-1:0]             m_p99_us
);

    logic                  enable_reg;
    logic                  cfg_wr;
    logic                  sel_enable;
    logic                  q_valid;
    logic                  q_pop;
    lhm_pkg::item_t        q_item;

    // Register decode
    assign pready     = 1'b1;
    assign sel_enable = (paddr[lhm_pkg::PADDR_W-1:2] == lhm_pkg::REG_ENABLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign prdata     = sel_enable ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_wr && sel_enable) begin
            enable_reg <= pwdata[0];
        end
    end

    lhm_front #(
        .NUM_METRICS (NUM_METRICS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (enable_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_metric     (s_metric),
        .s_latency_us (s_latency_us),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    lhm_back #(
        .NUM_METRICS (NUM_METRICS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket       (m_bucket),
        .m_sample_count (m_sample_count),
        .m_min_us       (m_min_us),
        .m_max_us       (m_max_us),
        .m_sum_us       (m_sum_us),
        .m_p50_us       (m_p50_us),
        .m_p95_us       (m_p95_us),
        .m_p99_us       (m_p99_us)
    );

endmodule

`default_nettype wire
